@@ src/assert_macros.svh @@
// Assertion helpers included by the blender unit.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising clock edge, skipped while reset is asserted.
`define FSB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fsb: assertion failed");

// Checked on every rising clock edge, reset included.
`define FSB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fsb: assertion failed");

`else

`define FSB_ASSERT(lbl, clk, rstn, prop)
`define FSB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ src/fsb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fsb_pkg;

  localparam int TIME_WIDTH_DEF = 16;
  localparam int DUR_W          = 16;
  localparam int ALPHA_W        = 9;
  localparam int QUOT_W         = 8;
  localparam int WORD_W         = 32;
  localparam int SHIFT_W        = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;
  localparam logic [SHIFT_W-1:0] ALPHA_POS  = 5'd24;

  // input transaction modes
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_USER     = 3'd1;
  localparam logic [2:0] MODE_FADE_IN  = 3'd2;
  localparam logic [2:0] MODE_FADE_OUT = 3'd3;
  localparam logic [2:0] MODE_FRAME    = 3'd4;
  localparam logic [2:0] MODE_PIXEL    = 3'd5;

  // fade phases
  localparam logic [2:0] PH_IN      = 3'd0;
  localparam logic [2:0] PH_VISIBLE = 3'd1;
  localparam logic [2:0] PH_OUT     = 3'd2;
  localparam logic [2:0] PH_WAITING = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_ALPHA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_CLOSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT = 3'd6;

  typedef struct packed {
    logic busy;
    logic done;
  } fsb_div_stat_t;

  // bg + floor((src - bg) * a / 256), low 8 bits
  function automatic logic [7:0] fsb_mix(input logic [7:0] src, input logic [7:0] bg,
                                         input logic [ALPHA_W-1:0] a);
    logic signed [9:0]  diff;
    logic signed [19:0] prod;
    logic [11:0]        frac;
    diff = $signed({2'b00, src}) - $signed({2'b00, bg});
    prod = diff * $signed({1'b0, a});
    frac = prod[19:8];
    return 8'(bg + frac[7:0]);
  endfunction

endpackage

`default_nettype wire

@@ src/fsb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fsb_in_if import fsb_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, mode, red, green, blue, input ready);
  modport sink   (input valid, mode, red, green, blue, output ready);
endinterface

interface fsb_out_if import fsb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  pixel_word;
  logic               pixel_valid;
  logic [ALPHA_W-1:0] alpha_level;
  logic [2:0]         phase_now;
  logic               is_done;
  logic               is_animating;

  modport source (output valid, pixel_word, pixel_valid, alpha_level, phase_now, is_done,
                  is_animating, input ready);
  modport sink   (input valid, pixel_word, pixel_valid, alpha_level, phase_now, is_done,
                  is_animating, output ready);
endinterface

`default_nettype wire

@@ src/fsb_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: quot = floor(num * 256 / den), num < den required.
// One quotient bit per cycle on a shared compare/subtract.
module fsb_div import fsb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DUR_W-1:0]  num_i,
  input  wire logic [DUR_W-1:0]  den_i,
  output fsb_div_stat_t          stat_o,
  output logic [QUOT_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(QUOT_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DUR_W-1:0]  rem_q;
  logic [QUOT_W-1:0] quot_q;

  logic [DUR_W:0]    rem2;
  logic              ge;
  logic [DUR_W:0]    diff;

  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {1'b0, den_i};
  assign diff = rem2 - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DUR_W-1:0] : rem2[DUR_W-1:0];
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

`default_nettype wire

@@ src/fade_sequencer_pixel_blender_unit.sv @@
// From accept to result: tick, user, start and frame-start transactions that need no division
// go from idle to the write state; a frame start mid-fade first passes the divide state
// (8-step divider), a pixel the pixel state (four passes through one shared 10x10 multiply-blend
// unit). Input is taken only when idle, so a new transaction waits until the last is written out.
// Reset (async, active low): phase fade in, counter and frame alpha zero, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fade_sequencer_pixel_blender_unit import fsb_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  fsb_in_if.sink                     item_i,
  fsb_out_if.source                  result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // elapsed and duration are compared at the wider of the two
  localparam int CMP_W = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_PIX   = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  // ---------------- configuration registers ----------------
  logic [DUR_W-1:0]   dur_q;
  logic               use_alpha_q;
  logic               auto_close_q;
  logic [23:0]        bg_q;
  logic [SHIFT_W-1:0] red_sh_q;
  logic [SHIFT_W-1:0] green_sh_q;
  logic [SHIFT_W-1:0] blue_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q        <= 16'd500;
      use_alpha_q  <= 1'b1;
      auto_close_q <= 1'b0;
      bg_q         <= '0;
      red_sh_q     <= 5'd16;
      green_sh_q   <= 5'd8;
      blue_sh_q    <= 5'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DURATION:    dur_q        <= cfg_wdata_i[DUR_W-1:0];
        REG_USE_ALPHA:   use_alpha_q  <= cfg_wdata_i[0];
        REG_AUTO_CLOSE:  auto_close_q <= cfg_wdata_i[0];
        REG_BACKGROUND:  bg_q         <= cfg_wdata_i[23:0];
        REG_RED_SHIFT:   red_sh_q     <= cfg_wdata_i[SHIFT_W-1:0];
        REG_GREEN_SHIFT: green_sh_q   <= cfg_wdata_i[SHIFT_W-1:0];
        REG_BLUE_SHIFT:  blue_sh_q    <= cfg_wdata_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- control and state ----------------
  logic [1:0]            state_q;
  logic [2:0]            phase_q;
  logic [TIME_WIDTH-1:0] elapsed_q;
  logic [ALPHA_W-1:0]    alpha_q;
  logic [1:0]            ch_q;        // 0 alpha, 1 red, 2 green, 3 blue
  logic                  pix_valid_q;
  logic [WORD_W-1:0]     word_q;
  logic [7:0]            src_r_q;
  logic [7:0]            src_g_q;
  logic [7:0]            src_b_q;

  // output register
  logic                  ovalid_q;
  logic [WORD_W-1:0]     o_word_q;
  logic                  o_pix_valid_q;
  logic [ALPHA_W-1:0]    o_alpha_q;
  logic [2:0]            o_phase_q;

  logic accept;
  logic fade_phase;
  logic fade_over;
  logic div_start;
  logic out_free;

  fsb_div_stat_t     div_stat;
  logic [QUOT_W-1:0] div_quot;

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign fade_phase   = (phase_q == PH_IN) || (phase_q == PH_OUT);
  assign fade_over    = CMP_W'(elapsed_q) >= CMP_W'(dur_q);
  assign div_start    = accept && (item_i.mode == MODE_FRAME) && fade_phase && !fade_over;
  assign out_free     = !ovalid_q || result_o.ready;

  // elapsed < duration here, so it fits the divider's numerator
  fsb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (DUR_W'(CMP_W'(elapsed_q))),
    .den_i   (dur_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  // ---------------- shared blend unit ----------------
  // Premultiply is a blend toward a black backdrop; the 8-bit alpha is 255 blended the same way.
  logic [7:0]         mix_src;
  logic [7:0]         mix_bg;
  logic [SHIFT_W-1:0] mix_sh;
  logic               mix_en;
  logic [7:0]         mix_val;
  logic [WORD_W-1:0]  mix_placed;

  always_comb begin
    mix_src = 8'hFF;
    mix_bg  = 8'h00;
    mix_sh  = ALPHA_POS;
    mix_en  = use_alpha_q;
    case (ch_q)
      2'd1: begin
        mix_src = src_r_q;
        mix_bg  = use_alpha_q ? 8'h00 : bg_q[23:16];
        mix_sh  = red_sh_q;
        mix_en  = 1'b1;
      end
      2'd2: begin
        mix_src = src_g_q;
        mix_bg  = use_alpha_q ? 8'h00 : bg_q[15:8];
        mix_sh  = green_sh_q;
        mix_en  = 1'b1;
      end
      2'd3: begin
        mix_src = src_b_q;
        mix_bg  = use_alpha_q ? 8'h00 : bg_q[7:0];
        mix_sh  = blue_sh_q;
        mix_en  = 1'b1;
      end
      default: ;
    endcase
  end

  assign mix_val    = fsb_mix(mix_src, mix_bg, alpha_q);
  // bits pushed above the word's top are dropped
  assign mix_placed = WORD_W'(mix_val) << mix_sh;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IN;
      elapsed_q   <= '0;
      alpha_q     <= '0;
      ch_q        <= '0;
      pix_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pix_valid_q <= (item_i.mode == MODE_PIXEL);
            state_q     <= ST_WRITE;
            case (item_i.mode)
              MODE_TICK: begin
                if (elapsed_q != '1) elapsed_q <= elapsed_q + 1'b1;
              end
              MODE_USER: begin
                if (phase_q == PH_VISIBLE) begin
                  phase_q   <= PH_OUT;
                  elapsed_q <= '0;
                end else if (phase_q == PH_WAITING) begin
                  phase_q <= PH_DONE;
                end
              end
              MODE_FADE_IN: begin
                phase_q   <= PH_IN;
                elapsed_q <= '0;
              end
              MODE_FADE_OUT: begin
                phase_q   <= PH_OUT;
                elapsed_q <= '0;
              end
              MODE_FRAME: begin
                if (div_start) begin
                  state_q <= ST_DIV;
                end else if (phase_q == PH_IN) begin
                  // fade in finished (or zero duration)
                  phase_q <= PH_VISIBLE;
                  alpha_q <= ALPHA_FULL;
                end else if (phase_q == PH_VISIBLE) begin
                  alpha_q <= ALPHA_FULL;
                end else if (phase_q == PH_OUT) begin
                  phase_q <= auto_close_q ? PH_DONE : PH_WAITING;
                  alpha_q <= '0;
                end else begin
                  alpha_q <= '0;
                end
              end
              MODE_PIXEL: begin
                ch_q    <= '0;
                state_q <= ST_PIX;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            alpha_q <= (phase_q == PH_IN) ? {1'b0, div_quot}
                                          : ALPHA_FULL - {1'b0, div_quot};
            state_q <= ST_WRITE;
          end
        end
        ST_PIX: begin
          ch_q <= ch_q + 1'b1;
          if (ch_q == 2'd3) state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // pixel datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q  <= '0;
      src_r_q <= item_i.red;
      src_g_q <= item_i.green;
      src_b_q <= item_i.blue;
    end else if (state_q == ST_PIX && mix_en) begin
      word_q <= word_q | mix_placed;   // overlapping channels OR together
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (state_q == ST_WRITE && out_free) begin
      ovalid_q <= 1'b1;
    end else if (result_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE && out_free) begin
      o_word_q      <= word_q;
      o_pix_valid_q <= pix_valid_q;
      o_alpha_q     <= alpha_q;
      o_phase_q     <= phase_q;
    end
  end

  assign result_o.valid        = ovalid_q;
  assign result_o.pixel_word   = o_word_q;
  assign result_o.pixel_valid  = o_pix_valid_q;
  assign result_o.alpha_level  = o_alpha_q;
  assign result_o.phase_now    = o_phase_q;
  assign result_o.is_done      = (o_phase_q == PH_DONE);
  assign result_o.is_animating = (o_phase_q == PH_IN) || (o_phase_q == PH_OUT);

  // ---------------- assertions ----------------
  `FSB_ASSERT(a_alpha_range, clk_i, rst_ni, alpha_q <= ALPHA_FULL)
  `FSB_ASSERT(a_phase_range, clk_i, rst_ni, phase_q <= PH_DONE)
  `FSB_ASSERT(a_idle_div_quiet, clk_i, rst_ni, (state_q == ST_IDLE) |-> !div_stat.busy)
  `FSB_ASSERT(a_div_only_in_div, clk_i, rst_ni, div_stat.done |-> (state_q == ST_DIV))
  `FSB_ASSERT(a_pixel_starts, clk_i, rst_ni, (accept && item_i.mode == MODE_PIXEL) |=> (state_q == ST_PIX))

endmodule

`default_nettype wire
